/* rtl/core/sidac_pkg.sv */
package sidac_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W = 4 * NUM_DIGITS;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;

	typedef logic [3:0] digit_idx_t;

	// Conversion state handed from stage to stage.
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] bin;
		logic [BCD_W-1:0]   bcd;
	} dd_t;

endpackage

/* rtl/core/signed_int_to_decimal_ascii.sv */
// Channel  Ports                       Handshake
// input    value                       start, busy (taken when start && !busy)
// output   character, last             strobe, one cycle, cannot be held off
//
// A value passes a magnitude stage and four binary-to-BCD stages of eight
// shift steps each, then reaches the character emitter. The emitter sends
// one character per cycle, so a value yields 1 to 11 characters (its digit
// count, plus one for a minus sign). A transaction waiting behind the emitter
// stalls the stages in place and busy rises once the first stage is held.
// Reset clears all valid bits.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic signed [31:0] value,
	output logic        busy,
	output logic        strobe,
	output logic [7:0]  character,
	output logic        last
);

	localparam int unsigned STEPS_PER_STAGE = 8;

	function automatic sidac_pkg::dd_t dd_step(input sidac_pkg::dd_t din);
		sidac_pkg::dd_t d;
		d = din;
		for (int s = 0; s < int'(STEPS_PER_STAGE); s++) begin
			for (int k = 0; k < int'(sidac_pkg::NUM_DIGITS); k++) begin
				if (d.bcd[4*k +: 4] >= 4'd5) begin
					d.bcd[4*k +: 4] = d.bcd[4*k +: 4] + 4'd3;
				end
			end
			d.bcd = {d.bcd[sidac_pkg::BCD_W-2:0], d.bin[sidac_pkg::VALUE_W-1]};
			d.bin = {d.bin[sidac_pkg::VALUE_W-2:0], 1'b0};
		end
		return d;
	endfunction

	logic           v_s1, v_s2, v_s3, v_s4, v_s5;
	sidac_pkg::dd_t dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	logic           rdy1, rdy2, rdy3, rdy4, rdy5;
	logic           emit_ready;
	logic [31:0]    raw;
	logic [31:0]    mag;

	assign rdy5 = !v_s5 || emit_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign busy = !rdy1;

	// The magnitude of the most negative value still fits as unsigned.
	assign raw = value;
	assign mag = raw[31] ? (~raw + 32'd1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= start;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && rdy1) begin
			dd_s1.neg <= raw[31];
			dd_s1.bin <= mag;
			dd_s1.bcd <= '0;
		end
		if (v_s1 && rdy2) begin
			dd_s2 <= dd_step(dd_s1);
		end
		if (v_s2 && rdy3) begin
			dd_s3 <= dd_step(dd_s2);
		end
		if (v_s3 && rdy4) begin
			dd_s4 <= dd_step(dd_s3);
		end
		if (v_s4 && rdy5) begin
			dd_s5 <= dd_step(dd_s4);
		end
	end

	sidac_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_dd     (dd_s5),
		.in_ready  (emit_ready),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule

/* rtl/core/sidac_emit.sv */
module sidac_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  sidac_pkg::dd_t in_dd,
	output logic           in_ready,
	output logic           strobe,
	output logic [7:0]     character,
	output logic           last
);

	logic                        active_q;
	logic                        sign_q;
	sidac_pkg::digit_idx_t       pos_q;
	logic [sidac_pkg::BCD_W-1:0] digits_q;
	logic                        strobe_q;
	logic [7:0]                  character_q;
	logic                        last_q;

	sidac_pkg::digit_idx_t top_idx;
	logic                  done_now;
	logic [3:0]            cur_digit;

	// Index of the most significant nonzero digit, zero when the value is zero.
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < int'(sidac_pkg::NUM_DIGITS); d++) begin
			if (in_dd.bcd[4*d +: 4] != 4'd0) begin
				top_idx = 4'(d);
			end
		end
	end

	assign done_now  = active_q && !sign_q && (pos_q == '0);
	assign in_ready  = !active_q || done_now;
	assign cur_digit = digits_q[{pos_q, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (in_valid && in_ready) begin
				active_q <= 1'b1;
				sign_q   <= in_dd.neg;
				pos_q    <= top_idx;
			end else if (active_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (pos_q != '0) begin
					pos_q <= pos_q - 4'd1;
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			digits_q <= in_dd.bcd;
		end
		if (active_q) begin
			character_q <= sign_q ? sidac_pkg::ASCII_MINUS
			                      : sidac_pkg::ASCII_ZERO + {4'b0000, cur_digit};
			last_q      <= !sign_q && (pos_q == '0);
		end
	end

	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;

endmodule
